@@ hw/rtl/csvs_pkg.sv @@
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types and constants of the chunked sparse voxel store.
// ----------------------------------------------------------------------------
package csvs_pkg;

   localparam int COORD_BITS  = 20;
   localparam int EDGE_BITS   = 4;
   localparam int CHUNK_BITS  = COORD_BITS - EDGE_BITS;
   localparam int VIDX_BITS   = 3 * EDGE_BITS;
   localparam int COUNT_BITS  = VIDX_BITS + 1;
   localparam int COLOUR_BITS = 8;
   localparam int FUNC_BITS   = 2;

   localparam logic [FUNC_BITS-1:0] FUNC_READ   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_WRITE  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_DELETE = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [FUNC_BITS-1:0]          func;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic signed [COORD_BITS-1:0]  pos_z;
      logic [COLOUR_BITS-1:0]        colour;
   } req_type;

   typedef struct packed {
      logic [COLOUR_BITS-1:0] read_colour;
      logic                   chunk_present;
      logic [COUNT_BITS-1:0]  filled_count;
      logic                   status;
   } rsp_type;

   typedef struct packed {
      logic [CHUNK_BITS-1:0] cx;
      logic [CHUNK_BITS-1:0] cy;
      logic [CHUNK_BITS-1:0] cz;
   } key_type;

   typedef struct packed {
      logic lookup;
      logic alloc;
      logic kill;
   } tag_cmd_type;

   typedef struct packed {
      logic hit;
      logic free_avail;
   } tag_stat_type;

   typedef struct packed {
      logic rd;
      logic vox_we;
      logic cnt_we;
   } mem_cmd_type;

endpackage

@@ hw/rtl/csvs_tags.sv @@
// ----------------------------------------------------------------------------
// csvs_tags
// Chunk tag table: valid bits, tag compare into a registered match vector,
// first-hit and first-free encoders, allocate and invalidate.
// ----------------------------------------------------------------------------
module csvs_tags #(
   parameter int CHUNK_SLOTS = 64,
   parameter int SLOT_BITS   = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  csvs_pkg::tag_cmd_type      cmd,
   input  logic [SLOT_BITS-1:0]       cmd_slot,
   input  csvs_pkg::key_type          key,
   output csvs_pkg::tag_stat_type     stat,
   output logic [SLOT_BITS-1:0]       hit_slot,
   output logic [SLOT_BITS-1:0]       free_slot
);

   logic [CHUNK_SLOTS-1:0] valid_ff;
   logic [CHUNK_SLOTS-1:0] valid_in;
   logic [CHUNK_SLOTS-1:0] match_in;
   logic [CHUNK_SLOTS-1:0] match_ff;
   logic [CHUNK_SLOTS-1:0] free_ff;
   csvs_pkg::key_type      tag_ff [CHUNK_SLOTS];

   always_comb begin
      for (int i = 0; i < CHUNK_SLOTS; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == key);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.alloc) begin
         valid_in[cmd_slot] = 1'b1;
      end
      if (cmd.kill) begin
         valid_in[cmd_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         match_ff <= match_in;
         free_ff  <= ~valid_ff;
      end
      if (cmd.alloc) begin
         tag_ff[cmd_slot] <= key;
      end
   end

   // lowest set bit wins
   always_comb begin
      hit_slot  = '0;
      free_slot = '0;
      for (int i = CHUNK_SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_slot = SLOT_BITS'(i);
         end
         if (free_ff[i]) begin
            free_slot = SLOT_BITS'(i);
         end
      end
      stat.hit        = |match_ff;
      stat.free_avail = |free_ff;
   end

endmodule

@@ hw/rtl/csvs_store.sv @@
// ----------------------------------------------------------------------------
// csvs_store
// Voxel memory and per-slot filled-count memory, single port each,
// registered read data.
// ----------------------------------------------------------------------------
module csvs_store #(
   parameter int CHUNK_SLOTS = 64,
   parameter int SLOT_BITS   = 6
) (
   input  logic                                           clock,
   input  csvs_pkg::mem_cmd_type                          cmd,
   input  logic [SLOT_BITS+csvs_pkg::VIDX_BITS-1:0]       vox_addr,
   input  logic [csvs_pkg::COLOUR_BITS-1:0]               vox_wdata,
   output logic [csvs_pkg::COLOUR_BITS-1:0]               vox_rdata,
   input  logic [SLOT_BITS-1:0]                           cnt_addr,
   input  logic [csvs_pkg::COUNT_BITS-1:0]                cnt_wdata,
   output logic [csvs_pkg::COUNT_BITS-1:0]                cnt_rdata
);

   localparam int DEPTH = CHUNK_SLOTS * (1 << csvs_pkg::VIDX_BITS);

   logic [csvs_pkg::COLOUR_BITS-1:0] vox_mem [DEPTH];
   logic [csvs_pkg::COUNT_BITS-1:0]  cnt_mem [CHUNK_SLOTS];
   logic [csvs_pkg::COLOUR_BITS-1:0] vox_rdata_ff;
   logic [csvs_pkg::COUNT_BITS-1:0]  cnt_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.vox_we) begin
         vox_mem[vox_addr] <= vox_wdata;
      end
      if (cmd.rd) begin
         vox_rdata_ff <= vox_mem[vox_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_we) begin
         cnt_mem[cnt_addr] <= cnt_wdata;
      end
      if (cmd.rd) begin
         cnt_rdata_ff <= cnt_mem[cnt_addr];
      end
   end

   assign vox_rdata = vox_rdata_ff;
   assign cnt_rdata = cnt_rdata_ff;

endmodule

@@ hw/rtl/chunked_sparse_voxel_store.sv @@
// ----------------------------------------------------------------------------
// chunked_sparse_voxel_store
// Sparse voxel volume held as up to CHUNK_SLOTS chunks of 16x16x16 voxels,
// with voxel read, voxel write and chunk delete commands.
// ----------------------------------------------------------------------------
// One command word is taken at a time: start is taken while busy is low, and
// every command returns exactly one response word on rsp_data, flagged by
// rsp_valid for a single cycle; the receiver must take it then, it cannot
// stall. A command that hits a chunk passes through tag compare into a
// registered match vector, slot encode and memory read, then the update of
// voxel and count memories; a miss, including a read of an absent chunk, or
// a delete responds after the slot encode. A write that allocates a chunk
// first clears the new slot in the voxel memory, one voxel per cycle, then
// reads the voxel and its count again before the update. A full table drops
// the write and reports status 1. No clearing is needed after reset.
module chunked_sparse_voxel_store #(
   parameter int CHUNK_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  csvs_pkg::req_type req_data,
   output logic              rsp_valid,
   output csvs_pkg::rsp_type rsp_data
);

   localparam int SLOT_BITS = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
   localparam int VB        = csvs_pkg::VIDX_BITS;
   localparam int EB        = csvs_pkg::EDGE_BITS;
   localparam int CB        = csvs_pkg::COORD_BITS;
   localparam int NB        = csvs_pkg::COUNT_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MATCH  = 3'd1;
   localparam logic [2:0] ST_ENCODE = 3'd2;
   localparam logic [2:0] ST_CLEAR  = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_UPDATE = 3'd5;

   logic [2:0]              state_ff, state_in;
   csvs_pkg::req_type       req_ff, req_in;
   logic [SLOT_BITS-1:0]    slot_ff, slot_in;
   logic [VB-1:0]           clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   csvs_pkg::rsp_type       rsp_ff, rsp_in;

   csvs_pkg::key_type       key;
   logic [VB-1:0]           vidx;
   csvs_pkg::tag_cmd_type   tag_cmd;
   logic [SLOT_BITS-1:0]    tag_slot;
   csvs_pkg::tag_stat_type  tag_stat;
   logic [SLOT_BITS-1:0]    hit_slot, free_slot;

   csvs_pkg::mem_cmd_type                mem_cmd;
   logic [SLOT_BITS-1:0]                 mem_slot;
   logic [VB-1:0]                        mem_vidx;
   logic [csvs_pkg::COLOUR_BITS-1:0]     vox_wdata, vox_rdata;
   logic [NB-1:0]                        cnt_wdata, cnt_rdata, cnt_new;
   logic                                 is_write;

   assign key.cx = req_ff.pos_x[CB-1:EB];
   assign key.cy = req_ff.pos_y[CB-1:EB];
   assign key.cz = req_ff.pos_z[CB-1:EB];
   assign vidx   = {req_ff.pos_x[EB-1:0], req_ff.pos_y[EB-1:0], req_ff.pos_z[EB-1:0]};
   assign is_write = (req_ff.func == csvs_pkg::FUNC_WRITE);

   always_comb begin
      if (vox_rdata == '0 && req_ff.colour != '0) begin
         cnt_new = cnt_rdata + NB'(1);
      end else if (vox_rdata != '0 && req_ff.colour == '0) begin
         cnt_new = cnt_rdata - NB'(1);
      end else begin
         cnt_new = cnt_rdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tag_cmd      = '0;
      tag_slot     = hit_slot;
      mem_cmd      = '0;
      mem_slot     = slot_ff;
      mem_vidx     = vidx;
      vox_wdata    = req_ff.colour;
      cnt_wdata    = cnt_new;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            tag_cmd.lookup = 1'b1;
            state_in       = ST_ENCODE;
         end
         ST_ENCODE: begin
            rsp_in   = '0;
            mem_slot = hit_slot;
            slot_in  = hit_slot;
            if (req_ff.func == csvs_pkg::FUNC_DELETE) begin
               tag_cmd.kill = tag_stat.hit;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (tag_stat.hit) begin
               mem_cmd.rd = 1'b1;
               state_in   = ST_UPDATE;
            end else if (is_write && tag_stat.free_avail) begin
               tag_cmd.alloc  = 1'b1;
               tag_slot       = free_slot;
               mem_slot       = free_slot;
               slot_in        = free_slot;
               mem_cmd.cnt_we = 1'b1;
               cnt_wdata      = '0;
               clr_in         = '0;
               state_in       = ST_CLEAR;
            end else begin
               rsp_in.status = is_write ? csvs_pkg::STATUS_FULL : csvs_pkg::STATUS_OK;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            mem_cmd.vox_we = 1'b1;
            mem_vidx       = clr_ff;
            vox_wdata      = '0;
            clr_in         = clr_ff + VB'(1);
            if (clr_ff == '1) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_cmd.rd = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            rsp_in.chunk_present = 1'b1;
            rsp_in.status        = csvs_pkg::STATUS_OK;
            if (is_write) begin
               mem_cmd.vox_we       = 1'b1;
               mem_cmd.cnt_we       = 1'b1;
               rsp_in.read_colour   = req_ff.colour;
               rsp_in.filled_count  = cnt_new;
            end else begin
               rsp_in.read_colour   = vox_rdata;
               rsp_in.filled_count  = cnt_rdata;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      slot_ff <= slot_in;
      clr_ff  <= clr_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   csvs_tags #(
      .CHUNK_SLOTS (CHUNK_SLOTS),
      .SLOT_BITS   (SLOT_BITS)
   ) u_tags (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tag_cmd),
      .cmd_slot  (tag_slot),
      .key       (key),
      .stat      (tag_stat),
      .hit_slot  (hit_slot),
      .free_slot (free_slot)
   );

   csvs_store #(
      .CHUNK_SLOTS (CHUNK_SLOTS),
      .SLOT_BITS   (SLOT_BITS)
   ) u_store (
      .clock     (clock),
      .cmd       (mem_cmd),
      .vox_addr  ({mem_slot, mem_vidx}),
      .vox_wdata (vox_wdata),
      .vox_rdata (vox_rdata),
      .cnt_addr  (mem_slot),
      .cnt_wdata (cnt_wdata),
      .cnt_rdata (cnt_rdata)
   );

endmodule
